// ----- src/tatc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tatc_pkg
// Shared constants, sequencer states and helpers for the thermistor
// average to temperature block.
// ----------------------------------------------------------------------------
package tatc_pkg;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [31:0] NUM_SCALE = 32'd2981500;     // 100 * 29815
  localparam logic [31:0] T25_CENTI_K = 32'd29815;
  localparam logic [15:0] KELVIN_CENTI = 16'd27315;
  localparam logic [15:0] KC_MAX = 16'd60082;          // 32767 + 27315
  localparam logic [15:0] T_MAX = 16'h7FFF;
  localparam logic [15:0] SAMPLE_MASK = 16'hFFFF;

  localparam logic [1:0] CFG_SAMPLES = 2'd0;
  localparam logic [1:0] CFG_SERIES = 2'd1;
  localparam logic [1:0] CFG_NOMINAL = 2'd2;
  localparam logic [1:0] CFG_BETA = 2'd3;

  localparam logic [1:0] ST_VALID = 2'd0;
  localparam logic [1:0] ST_OPEN = 2'd1;
  localparam logic [1:0] ST_SHORT = 2'd2;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_AVG  = 11'b000_0000_0010,
    S_RMUL = 11'b000_0000_0100,
    S_RDIV = 11'b000_0000_1000,
    S_LOGN = 11'b000_0001_0000,
    S_SQ   = 11'b000_0010_0000,
    S_LN   = 11'b000_0100_0000,
    S_NUM  = 11'b000_1000_0000,
    S_DMUL = 11'b001_0000_0000,
    S_KDIV = 11'b010_0000_0000,
    S_DONE = 11'b100_0000_0000
  } state_t;

  // leading-one position of a nonzero 16-bit value
  function automatic logic [3:0] msb_index(input logic [15:0] x);
    logic [3:0] e;
    e = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (x[i]) begin
        e = 4'(i);
      end
    end
    return e;
  endfunction

endpackage

// ----- src/tatc_smul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tatc_smul
// Bit-serial shift-add multiplier, 32 x 32 bits, one multiplier bit a cycle.
// ----------------------------------------------------------------------------
module tatc_smul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [63:0] p
);

  logic [31:0] acc_hi;
  logic [31:0] mq;
  logic [31:0] mcand;
  logic [4:0]  cnt;
  logic        busy;
  logic [32:0] sum;

  assign sum = {1'b0, acc_hi} + (mq[0] ? {1'b0, mcand} : 33'd0);
  assign p = {acc_hi, mq};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 5'd0;
        acc_hi <= 32'd0;
        mq <= b;
        mcand <= a;
      end else if (busy) begin
        acc_hi <= sum[32:1];
        mq <= {sum[0], mq[31:1]};
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- src/tatc_sdiv.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tatc_sdiv
// Restoring bit-serial divider, 64-bit dividend by 48-bit divisor,
// one quotient bit a cycle.
// ----------------------------------------------------------------------------
module tatc_sdiv (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] n,
  input  logic [47:0] d,
  output logic        done,
  output logic [63:0] q
);

  logic [47:0] rem;
  logic [47:0] dvs;
  logic [63:0] quo;
  logic [5:0]  cnt;
  logic        busy;
  logic [48:0] trial;

  assign trial = {rem, quo[63]} - {1'b0, dvs};
  assign q = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 6'd0;
        rem <= 48'd0;
        dvs <= d;
        quo <= n;
      end else if (busy) begin
        if (!trial[48]) begin
          rem <= trial[47:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= {rem[46:0], quo[63]};
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- src/thermistor_average_to_temperature.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermistor_average_to_temperature
// Window average of thermistor divider samples, resistance and Beta equation
// temperature in hundredths of a degree Celsius.
// ----------------------------------------------------------------------------
// Samples are taken one beat per cycle while a window fills. The beat that
// closes a window starts a conversion, during which in_stall is high: up to
// three divisions in the serial divider and thirty-seven products in the
// serial multiplier, most of them the sixteen squarings of each of the two
// logarithms. One result beat leaves per window; it waits in the output
// register while the next window fills.
module thermistor_average_to_temperature (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] temperature_centi,
  output logic [1:0]         status,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  tatc_pkg::state_t state;

  logic [7:0]  samples_per_average;
  logic [15:0] series_ohms;
  logic [15:0] nominal_ohms;
  logic [15:0] beta_value;

  logic [23:0] sample_sum;
  logic [7:0]  sample_count;
  logic [23:0] win_sum;
  logic [7:0]  win_cnt;
  logic [15:0] avg;
  logic [15:0] xv;
  logic [31:0] mant;
  logic [15:0] frac;
  logic [3:0]  ex;
  logic [3:0]  sqn;
  logic        pass;
  logic [19:0] ln_r;
  logic [19:0] ln_nom;
  logic [53:0] numv;
  logic        launched;
  logic [15:0] res_t;
  logic [1:0]  res_st;

  logic        in_take;
  logic [23:0] sum_next;
  logic [7:0]  cnt_next;
  logic [7:0]  n_eff;
  logic [15:0] nom_eff;
  logic [15:0] b_eff;
  logic        close;
  logic        out_load;

  logic        mul_start;
  logic        mul_done;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic        div_start;
  logic        div_done;
  logic [63:0] div_n;
  logic [47:0] div_d;
  logic [63:0] div_q;

  logic [15:0] r_val;
  logic [19:0] ln_val;
  logic signed [20:0] dlog;
  logic [20:0] dabs;
  logic [22:0] b100;
  logic signed [40:0] den;
  logic        den_ok;
  logic        mul_state;

  assign in_stall = (state != tatc_pkg::S_IDLE);
  assign in_take = in_valid && !in_stall;
  assign sum_next = sample_sum + {8'd0, sample & tatc_pkg::SAMPLE_MASK};
  assign cnt_next = sample_count + 8'd1;
  assign n_eff = (samples_per_average == 8'd0) ? 8'd1 : samples_per_average;
  assign nom_eff = (nominal_ohms == 16'd0) ? 16'd1 : nominal_ohms;
  assign b_eff = (beta_value == 16'd0) ? 16'd1 : beta_value;
  assign close = (cnt_next == 8'd0) || (cnt_next >= n_eff);
  assign out_load = (state == tatc_pkg::S_DONE) && (!out_valid || !out_stall);

  assign r_val = (|div_q[63:16]) ? 16'hFFFF : div_q[15:0];
  assign ln_val = mul_p[51:32] + {19'd0, mul_p[31]};
  assign dlog = $signed({1'b0, ln_r}) - $signed({1'b0, ln_nom});
  assign dabs = dlog[20] ? 21'(-dlog) : dlog;
  assign b100 = {7'd0, b_eff} * 23'd100;
  assign den = $signed({2'b00, b100, 16'd0})
             + (dlog[20] ? -$signed({5'd0, mul_p[35:0]})
                         : $signed({5'd0, mul_p[35:0]}));
  assign den_ok = !den[40] && (den != 41'sd0);

  assign mul_state = (state == tatc_pkg::S_RMUL) || (state == tatc_pkg::S_SQ)
                  || (state == tatc_pkg::S_LN) || (state == tatc_pkg::S_NUM)
                  || (state == tatc_pkg::S_DMUL);
  assign mul_start = !launched && mul_state;
  assign div_start = !launched && ((state == tatc_pkg::S_AVG)
                  || (state == tatc_pkg::S_RDIV)
                  || ((state == tatc_pkg::S_KDIV) && den_ok));

  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (state)
      tatc_pkg::S_RMUL: begin
        mul_a = {16'd0, series_ohms};
        mul_b = {16'd0, avg};
      end
      tatc_pkg::S_SQ: begin
        mul_a = mant;
        mul_b = mant;
      end
      tatc_pkg::S_LN: begin
        mul_a = tatc_pkg::LN2_Q32;
        mul_b = {12'd0, ex, frac};
      end
      tatc_pkg::S_NUM: begin
        mul_a = {16'd0, b_eff};
        mul_b = tatc_pkg::NUM_SCALE;
      end
      tatc_pkg::S_DMUL: begin
        mul_a = tatc_pkg::T25_CENTI_K;
        mul_b = {11'd0, dabs};
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  always_comb begin
    div_n = 64'd0;
    div_d = 48'd1;
    case (state)
      tatc_pkg::S_AVG: begin
        div_n = {40'd0, win_sum};
        div_d = {40'd0, win_cnt};
      end
      tatc_pkg::S_RDIV: begin
        div_n = {32'd0, mul_p[31:0]};
        div_d = 48'(17'h10000 - {1'b0, avg});
      end
      tatc_pkg::S_KDIV: begin
        div_n = {10'd0, numv} + {24'd0, den[40:1]};
        div_d = {8'd0, den[39:0]};
      end
      default: begin
        div_n = 64'd0;
        div_d = 48'd1;
      end
    endcase
  end

  tatc_smul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  tatc_sdiv u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .n     (div_n),
    .d     (div_d),
    .done  (div_done),
    .q     (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_per_average <= 8'd100;
      series_ohms <= 16'd10000;
      nominal_ohms <= 16'd10000;
      beta_value <= 16'd3977;
    end else if (cfg_write) begin
      case (cfg_index)
        tatc_pkg::CFG_SAMPLES: samples_per_average <= cfg_data[7:0];
        tatc_pkg::CFG_SERIES:  series_ohms <= cfg_data;
        tatc_pkg::CFG_NOMINAL: nominal_ohms <= cfg_data;
        tatc_pkg::CFG_BETA:    beta_value <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tatc_pkg::S_IDLE;
      sample_sum <= 24'd0;
      sample_count <= 8'd0;
      launched <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (mul_start || div_start) begin
        launched <= 1'b1;
      end else if (mul_done || div_done) begin
        launched <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        tatc_pkg::S_IDLE: begin
          if (in_take) begin
            if (close) begin
              win_sum <= sum_next;
              win_cnt <= cnt_next;
              sample_sum <= 24'd0;
              sample_count <= 8'd0;
              if (cnt_next == 8'd0) begin
                res_t <= 16'd0;
                res_st <= tatc_pkg::ST_OPEN;
                state <= tatc_pkg::S_DONE;
              end else begin
                state <= tatc_pkg::S_AVG;
              end
            end else begin
              sample_sum <= sum_next;
              sample_count <= cnt_next;
            end
          end
        end
        tatc_pkg::S_AVG: begin
          if (div_done) begin
            avg <= div_q[15:0];
            if (div_q[15:0] == 16'd0) begin
              res_t <= 16'd0;
              res_st <= tatc_pkg::ST_OPEN;
              state <= tatc_pkg::S_DONE;
            end else if (div_q[15:0] >= tatc_pkg::SAMPLE_MASK) begin
              res_t <= 16'd0;
              res_st <= tatc_pkg::ST_SHORT;
              state <= tatc_pkg::S_DONE;
            end else begin
              state <= tatc_pkg::S_RMUL;
            end
          end
        end
        tatc_pkg::S_RMUL: begin
          if (mul_done) begin
            state <= tatc_pkg::S_RDIV;
          end
        end
        tatc_pkg::S_RDIV: begin
          if (div_done) begin
            if (r_val == 16'd0) begin
              res_t <= 16'd0 - tatc_pkg::KELVIN_CENTI;
              res_st <= tatc_pkg::ST_VALID;
              state <= tatc_pkg::S_DONE;
            end else begin
              xv <= r_val;
              pass <= 1'b0;
              state <= tatc_pkg::S_LOGN;
            end
          end
        end
        tatc_pkg::S_LOGN: begin
          ex <= tatc_pkg::msb_index(xv);
          mant <= {16'd0, xv} << (5'd31 - {1'b0, tatc_pkg::msb_index(xv)});
          frac <= 16'd0;
          sqn <= 4'd0;
          state <= tatc_pkg::S_SQ;
        end
        tatc_pkg::S_SQ: begin
          if (mul_done) begin
            mant <= mul_p[63] ? mul_p[63:32] : mul_p[62:31];
            frac <= {frac[14:0], mul_p[63]};
            sqn <= sqn + 4'd1;
            if (sqn == 4'd15) begin
              state <= tatc_pkg::S_LN;
            end
          end
        end
        tatc_pkg::S_LN: begin
          if (mul_done) begin
            if (!pass) begin
              ln_r <= ln_val;
              xv <= nom_eff;
              pass <= 1'b1;
              state <= tatc_pkg::S_LOGN;
            end else begin
              ln_nom <= ln_val;
              state <= tatc_pkg::S_NUM;
            end
          end
        end
        tatc_pkg::S_NUM: begin
          if (mul_done) begin
            numv <= {mul_p[37:0], 16'd0};
            state <= tatc_pkg::S_DMUL;
          end
        end
        tatc_pkg::S_DMUL: begin
          if (mul_done) begin
            state <= tatc_pkg::S_KDIV;
          end
        end
        tatc_pkg::S_KDIV: begin
          if (!launched && !den_ok) begin
            res_t <= tatc_pkg::T_MAX;
            res_st <= tatc_pkg::ST_VALID;
            state <= tatc_pkg::S_DONE;
          end else if (div_done) begin
            if ((|div_q[63:16]) || (div_q[15:0] > tatc_pkg::KC_MAX)) begin
              res_t <= tatc_pkg::T_MAX;
            end else begin
              res_t <= div_q[15:0] - tatc_pkg::KELVIN_CENTI;
            end
            res_st <= tatc_pkg::ST_VALID;
            state <= tatc_pkg::S_DONE;
          end
        end
        tatc_pkg::S_DONE: begin
          if (out_load) begin
            temperature_centi <= res_t;
            status <= res_st;
            state <= tatc_pkg::S_IDLE;
          end
        end
        default: begin
          state <= tatc_pkg::S_IDLE;
        end
      endcase
    end
  end

  a_mul_done_state: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> mul_state)
    else $error("multiplier finished outside a product step");

  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(mul_done && div_done))
    else $error("multiplier and divider finished together");

  a_flag_zero_temp: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != tatc_pkg::ST_VALID)) |-> (temperature_centi == 16'sd0))
    else $error("flagged beat carries a temperature");

  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    $past(in_take) && (state == tatc_pkg::S_AVG) |-> in_stall)
    else $error("input taken during conversion");

endmodule
